// File: rtl/fwacl_pkg.sv
`default_nettype none

package fwacl_pkg;

    // table depth default
    localparam int RULE_DEPTH_DEF = 64;

    // configuration port geometry and register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DENY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT   = 2'd1;

    // item modes
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // input item
    typedef struct packed {
        logic        mode;
        logic [5:0]  rule_index;
        logic [31:0] addr_one;
        logic [15:0] port_one_low;
        logic [15:0] port_one_high;
        logic [31:0] addr_two;
        logic [15:0] port_two_low;
        logic [15:0] port_two_high;
        logic        deny_flag;
    } in_item_t;

    // result item
    typedef struct packed {
        logic       deny;
        logic       rule_hit;
        logic [5:0] hit_index;
        logic       hit_reverse;
    } out_item_t;

    // one stored rule
    typedef struct packed {
        logic [31:0] addr_a;
        logic [15:0] port_a_hi;
        logic [15:0] port_a_lo;
        logic [31:0] addr_b;
        logic [15:0] port_b_hi;
        logic [15:0] port_b_lo;
        logic        policy;
    } rule_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FWD,
        ST_REV,
        ST_FINISH
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic rule_write;
        logic pkt_load;
        logic scan_start;
        logic rev_start;
        logic issue;
        logic hit_set;
        logic res_load;
    } ctl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic pend_match;
        logic ptr_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/fwacl_ctrl.sv
`default_nettype none

module fwacl_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_mode,
    output logic                       in_ready,
    input  wire fwacl_pkg::dp_status_t status,
    output fwacl_pkg::ctl_cmd_t        cmd
);
    import fwacl_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_mode == MODE_WRITE)
                    begin
                        cmd.rule_write = 1'b1;
                    end
                    else
                    begin
                        cmd.pkt_load   = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next     = ST_FWD;
                    end
                end
            end
            ST_FWD, ST_REV:
            begin
                if (status.pend_match)
                begin
                    cmd.hit_set = 1'b1;
                    state_next  = ST_FINISH;
                end
                else if (!status.ptr_done)
                begin
                    cmd.issue = 1'b1;
                end
                else if (state_reg == ST_FWD)
                begin
                    cmd.rev_start = 1'b1;
                    state_next    = ST_REV;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/fwacl_dp.sv
`default_nettype none

module fwacl_dp #(
    parameter int RULE_DEPTH = fwacl_pkg::RULE_DEPTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire fwacl_pkg::in_item_t                  in_data,
    input  wire logic                                 cfg_valid,
    input  wire logic [fwacl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [fwacl_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output fwacl_pkg::out_item_t                      out_data,
    input  wire fwacl_pkg::ctl_cmd_t                  cmd,
    output fwacl_pkg::dp_status_t                     status
);
    import fwacl_pkg::*;

    localparam int AW_RAW = $clog2(RULE_DEPTH);
    localparam int AW     = (AW_RAW < 1) ? 1 : AW_RAW;
    localparam int CW     = $clog2(RULE_DEPTH + 1);
    localparam int CMP_W  = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

    // rule table
    rule_t mem [RULE_DEPTH];
    rule_t rd_q_reg;

    // configuration registers
    logic                  default_deny_reg;
    logic [CFG_DATA_W-1:0] rule_count_reg;

    // packet under lookup
    logic [31:0] src_addr_reg;
    logic [15:0] src_port_reg;
    logic [31:0] dst_addr_reg;
    logic [15:0] dst_port_reg;

    // scan control
    logic [CW-1:0] ptr_reg;
    logic [CW-1:0] ptr_next;
    logic [AW-1:0] pend_idx_reg;
    logic          pend_reg;
    logic          rev_reg;

    // found rule
    logic          found_reg;
    logic [AW-1:0] found_idx_reg;
    logic          found_rev_reg;
    logic          found_pol_reg;

    // result register
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t res;

    logic [AW-1:0] wr_addr;
    logic          wr_in_range;
    logic [31:0]   near_addr;
    logic [31:0]   far_addr;
    logic          a_eq;
    logic          pa_holds;
    logic          pb_holds;
    logic          rule_match;

    // rule write address and range check
    assign wr_addr     = AW'(in_data.rule_index);
    assign wr_in_range = (32'(in_data.rule_index) < 32'(RULE_DEPTH));

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.rule_write && wr_in_range)
        begin
            mem[wr_addr] <= '{
                addr_a:    in_data.addr_one,
                port_a_hi: in_data.port_one_high,
                port_a_lo: in_data.port_one_low,
                addr_b:    in_data.addr_two,
                port_b_hi: in_data.port_two_high,
                port_b_lo: in_data.port_two_low,
                policy:    in_data.deny_flag
            };
        end
        if (cmd.issue)
        begin
            rd_q_reg <= mem[ptr_reg[AW-1:0]];
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_deny_reg <= 1'b0;
            rule_count_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DEFAULT_DENY: default_deny_reg <= cfg_data[0];
                CFG_RULE_COUNT:   rule_count_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // packet capture
    always_ff @(posedge clk)
    begin
        if (cmd.pkt_load)
        begin
            src_addr_reg <= in_data.addr_one;
            src_port_reg <= in_data.port_one_low;
            dst_addr_reg <= in_data.addr_two;
            dst_port_reg <= in_data.port_two_low;
        end
    end

    // scan pointer, read-pending flag and pass
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.scan_start || cmd.rev_start)
        begin
            ptr_next = '0;
        end
        else if (cmd.issue)
        begin
            ptr_next = ptr_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            pend_reg <= 1'b0;
            rev_reg  <= 1'b0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            pend_reg <= cmd.issue;
            if (cmd.scan_start)
            begin
                rev_reg <= 1'b0;
            end
            else if (cmd.rev_start)
            begin
                rev_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            pend_idx_reg <= ptr_reg[AW-1:0];
        end
    end

    // match test on the rule just read
    assign near_addr  = rev_reg ? dst_addr_reg : src_addr_reg;
    assign far_addr   = rev_reg ? src_addr_reg : dst_addr_reg;
    assign a_eq       = (rd_q_reg.addr_a == near_addr);
    assign pa_holds   = (rd_q_reg.port_a_lo <= src_port_reg) &&
                        (src_port_reg <= rd_q_reg.port_a_hi);
    assign pb_holds   = (rd_q_reg.port_b_lo <= dst_port_reg) &&
                        (dst_port_reg <= rd_q_reg.port_b_hi);
    assign rule_match = a_eq && pb_holds &&
                        (pa_holds ? (rd_q_reg.addr_b == far_addr)
                                  : (rd_q_reg.addr_b == 32'd0));

    // found rule capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.hit_set)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hit_set)
        begin
            found_idx_reg <= pend_idx_reg;
            found_rev_reg <= rev_reg;
            found_pol_reg <= rd_q_reg.policy;
        end
    end

    // result assembly
    always_comb
    begin
        res.deny        = found_reg ? found_pol_reg : default_deny_reg;
        res.rule_hit    = found_reg;
        res.hit_index   = found_reg ? 6'(found_idx_reg) : 6'd0;
        res.hit_reverse = found_reg & found_rev_reg;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // status to controller
    assign status.pend_match = pend_reg && rule_match;
    assign status.ptr_done   = (CMP_W'(ptr_reg) >= CMP_W'(rule_count_reg)) ||
                               (ptr_reg == CW'(RULE_DEPTH));
    assign status.out_free   = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

// File: rtl/firewall_acl_first_match_core.sv
// Packet filter rule table with first-match lookup.
//
// Input channel (in_valid/in_ready/in_data): a write item (mode 0) stores one
// rule at rule_index, when rule_index < RULE_DEPTH, and yields no result; a lookup item
// (mode 1) scans rules 0 to min(rule_count, RULE_DEPTH)-1, first with address A
// against the source, then, if none hit, again against the destination.
// Output channel (out_valid/out_ready/out_data): one result per lookup.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is
// default_deny, index 1 is rule_count; always ready, write only while idle.
// The table is one memory with a single registered read port, read one rule per
// cycle; a lookup ends its scan at the first rule that hits.
// One lookup is in flight at a time; a new item is taken once the result sits
// in the output register, even while that result waits to be taken.
// If the receiver stalls, the result holds in the output register and the
// next lookup waits after its scan until that register frees up.
// Reset clears control and configuration; rule table contents are undefined
// until written.
`default_nettype none

module firewall_acl_first_match_core #(
    parameter int RULE_DEPTH = fwacl_pkg::RULE_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire fwacl_pkg::in_item_t               in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output fwacl_pkg::out_item_t                   out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fwacl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fwacl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fwacl_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    // configuration writes complete at once
    assign cfg_ready = 1'b1;

    // sequencer
    fwacl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_mode  (in_data.mode),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // rule table, compare and result register
    fwacl_dp #(
        .RULE_DEPTH (RULE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire
